@@ rtl/lpkc_pkg.sv @@
// lpkc_pkg: shared types and constants of the linear probe key counter
// no dependencies; used by lpkc_front, lpkc_queue, lpkc_back and the top level
`timescale 1ns / 1ps

package lpkc_pkg;

  localparam int KEY_W       = 16;
  localparam int COUNT_W     = 16;
  localparam int SLOT_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = KEY_W / DIV_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_PROBE
  } back_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

@@ rtl/lpkc_front.sv @@
// lpkc_front: accepts keys, flags zero keys and reduces the key to its home slot
// depends on lpkc_pkg; feeds lpkc_queue
`timescale 1ns / 1ps

module lpkc_front #(
  parameter int TABLE_SIZE = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lpkc_pkg::KEY_W-1:0] in_key,
  input  logic                       q_full,
  output logic                       push,
  output logic [lpkc_pkg::KEY_W-1:0] push_key,
  output logic [$clog2(TABLE_SIZE)-1:0] push_home,
  output logic                       push_zero
);

  import lpkc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int REM_W = IDX_W + 1;

  front_state_t      state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  sh_r, sh_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              zero_r, zero_nxt;
  logic [IDX_W-1:0]  rem_step;
  logic              accept;

  assign accept = start && (state_r == F_IDLE);

  // restoring remainder, DIV_BITS key bits per cycle
  always_comb begin
    logic [REM_W-1:0] acc;
    acc = {1'b0, rem_r};
    for (int i = 0; i < DIV_BITS; i++) begin
      acc = {acc[REM_W-2:0], sh_r[KEY_W-1-i]};
      if (acc >= REM_W'(TABLE_SIZE)) begin
        acc = acc - REM_W'(TABLE_SIZE);
      end
    end
    rem_step = acc[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = (in_key == '0) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    key_nxt  = key_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    zero_nxt = zero_r;
    push     = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          key_nxt  = in_key;
          sh_nxt   = in_key;
          rem_nxt  = '0;
          step_nxt = '0;
          zero_nxt = (in_key == '0);
        end
      end
      F_DIV: begin
        rem_nxt  = rem_step;
        sh_nxt   = sh_r << DIV_BITS;
        step_nxt = step_r + STEP_W'(1);
      end
      F_PUSH: begin
        push = !q_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    zero_r <= zero_nxt;
  end

  assign busy      = (state_r != F_IDLE);
  assign push_key  = key_r;
  assign push_home = zero_r ? '0 : rem_r;
  assign push_zero = zero_r;

endmodule

@@ rtl/lpkc_queue.sv @@
// lpkc_queue: short register queue between the front and back parts
// depends on lpkc_pkg for its depth
`timescale 1ns / 1ps

module lpkc_queue #(
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  import lpkc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/lpkc_back.sv @@
// lpkc_back: probe sequencer over the slot memory, updates counts and drives results
// depends on lpkc_pkg; takes work from lpkc_queue
`timescale 1ns / 1ps

module lpkc_back #(
  parameter int TABLE_SIZE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [lpkc_pkg::KEY_W-1:0]    q_key,
  input  logic [$clog2(TABLE_SIZE)-1:0] q_home,
  input  logic                          q_zero,
  output logic                          pop,
  output logic                          out_valid,
  output logic [lpkc_pkg::SLOT_W-1:0]   out_slot,
  output logic [lpkc_pkg::COUNT_W-1:0]  out_count,
  output logic [lpkc_pkg::STATUS_W-1:0] out_status
);

  import lpkc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  back_state_t        state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  entry_t             mem_r [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  entry_t             rd_data_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  entry_t             wr_entry;
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   next_pos;
  logic               hit, is_empty, found;
  logic [COUNT_W-1:0] cur_cnt, inc_cnt;

  assign next_pos = (pos_r == LAST) ? '0 : pos_r + IDX_W'(1);
  assign hit      = rd_vld_r && (rd_data_r.key == key_r);
  assign is_empty = !rd_vld_r;
  assign found    = hit || is_empty;
  assign cur_cnt  = rd_vld_r ? rd_data_r.count : '0;
  assign inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && !q_zero) begin
          state_nxt = B_PROBE;
        end
      end
      B_PROBE: begin
        if (found || (n_r == LAST)) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    pop            = 1'b0;
    rd_addr        = next_pos;
    wr_en          = 1'b0;
    wr_entry.key   = key_r;
    wr_entry.count = inc_cnt;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    case (state_r)
      B_IDLE: begin
        rd_addr = q_home;
        if (!q_empty) begin
          pop     = 1'b1;
          key_nxt = q_key;
          pos_nxt = q_home;
          n_nxt   = '0;
          if (q_zero) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_count_nxt  = '0;
            out_status_nxt = ST_ZERO;
          end
        end
      end
      B_PROBE: begin
        if (found) begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SLOT_W'(pos_r);
          out_count_nxt  = inc_cnt;
          out_status_nxt = hit ? ST_PRESENT : ST_NEW;
        end else if (n_r == LAST) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_count_nxt  = '0;
          out_status_nxt = ST_FULL;
        end else begin
          pos_nxt = next_pos;
          n_nxt   = n_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[pos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[pos_r] <= wr_entry;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == B_PROBE) && found)
    else $error("slot write outside a probe hit");

  a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NEW)) |-> (out_count_r == COUNT_W'(1)))
    else $error("new key without a count of one");

  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_PRESENT)) |-> (out_count_r >= COUNT_W'(2)))
    else $error("present key with a count below two");

  a_full_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |->
      ($past(n_r) == LAST) && (out_slot_r == '0) && (out_count_r == '0))
    else $error("table full reported before a full sweep");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt |-> (state_r == B_PROBE) || (pop && q_zero))
    else $error("result without a finished probe or a zero key");
`endif

endmodule

@@ rtl/linear_probe_key_counter_core.sv @@
// linear_probe_key_counter_core: top level of the linear probe key counter
// depends on lpkc_pkg, lpkc_front, lpkc_queue and lpkc_back
`timescale 1ns / 1ps

// usage:
// a key on in_key is transferred at a rising edge with start high and busy low.
// busy stays high after a nonzero key through 4 remainder steps of 4 key
// bits each and then the queue push, and after a zero key through the queue
// push alone, longer while the queue is full.
// each key gives exactly one result on out_slot, out_count and out_status,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// the probe sequencer fetches the home slot, then probes 1 to TABLE_SIZE slots,
// one slot memory read per probe cycle; the result is registered and shows in
// the cycle after the last probe. a two entry queue lets the front take the
// next key while the back is still probing.
// a zero key gives status zero-rejected without touching the table.
// reset clears the slot valid bits at once, so the table reads as empty with
// no clearing pass; results come out in transfer order.
module linear_probe_key_counter_core #(
  parameter int TABLE_SIZE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpkc_pkg::KEY_W-1:0]    in_key,
  output logic                          out_valid,
  output logic [lpkc_pkg::SLOT_W-1:0]   out_slot,
  output logic [lpkc_pkg::COUNT_W-1:0]  out_count,
  output logic [lpkc_pkg::STATUS_W-1:0] out_status
);

  import lpkc_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int DATA_W = 1 + IDX_W + KEY_W;

  logic              push, q_full, q_empty, pop;
  logic [KEY_W-1:0]  push_key, q_key;
  logic [IDX_W-1:0]  push_home, q_home;
  logic              push_zero, q_zero;
  logic [DATA_W-1:0] push_data, pop_data;

  lpkc_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_key    (in_key),
    .q_full    (q_full),
    .push      (push),
    .push_key  (push_key),
    .push_home (push_home),
    .push_zero (push_zero)
  );

  assign push_data = {push_zero, push_home, push_key};

  lpkc_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  assign q_key  = pop_data[KEY_W-1:0];
  assign q_home = pop_data[KEY_W +: IDX_W];
  assign q_zero = pop_data[DATA_W-1];

  lpkc_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_key      (q_key),
    .q_home     (q_home),
    .q_zero     (q_zero),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_slot   (out_slot),
    .out_count  (out_count),
    .out_status (out_status)
  );

endmodule

@@ tb/linear_probe_key_counter_core_test.sv @@
// linear_probe_key_counter_core_test: self-checking bench for the key counter core
// keeps its own copy of the hash table, predicts slot, count and status per key
// depends on lpkc_pkg and linear_probe_key_counter_core
`timescale 1ns / 1ps

module linear_probe_key_counter_core_test;
  import lpkc_pkg::*;

  localparam int TABLE_SIZE = 8;
  localparam int RANDOM_KEYS = 850;

  typedef struct {
    logic [KEY_W-1:0] key;
    bit drain;
    bit paced;
  } key_item_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [COUNT_W-1:0] count;
    status_t status;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [KEY_W-1:0] in_key = '0;
  logic busy;
  logic out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic [COUNT_W-1:0] out_count;
  logic [STATUS_W-1:0] out_status;

  logic [KEY_W-1:0] held_key [TABLE_SIZE];
  logic [COUNT_W-1:0] held_count [TABLE_SIZE];
  key_item_t pending_keys [$];
  tally_t expected_tallies [$];
  logic [KEY_W-1:0] stored_pool [$];

  int err_count = 0;
  int status_seen [4];
  int top_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  bit took = 1'b0;

  linear_probe_key_counter_core #(.TABLE_SIZE(TABLE_SIZE)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_slot(out_slot),
    .out_count(out_count),
    .out_status(out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      held_key[i] = '0;
      held_count[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // probe from the home slot with wraparound, insert or bump the count, else report full or zero
  function automatic tally_t count_key(input logic [KEY_W-1:0] key);
    tally_t r;
    int home;
    int pos;
    bit hit;
    bit hole;
    r.slot = '0;
    r.count = '0;
    r.status = ST_ZERO;
    hit = 1'b0;
    hole = 1'b0;
    pos = 0;
    if (key == '0) return r;
    home = key % TABLE_SIZE;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      pos = (home + n) % TABLE_SIZE;
      if (held_key[pos] == key) begin
        hit = 1'b1;
        break;
      end
      if (held_key[pos] == '0) begin
        hole = 1'b1;
        break;
      end
    end
    if (!hit && !hole) begin
      r.status = ST_FULL;
      return r;
    end
    if (hole) begin
      held_key[pos] = key;
      held_count[pos] = '0;
    end
    if (held_count[pos] != '1) held_count[pos] = held_count[pos] + 1'b1;
    r.slot = pos[SLOT_W-1:0];
    r.count = held_count[pos];
    r.status = hit ? ST_PRESENT : ST_NEW;
    return r;
  endfunction

  task automatic queue_key(input logic [KEY_W-1:0] key, input bit drain, input bit paced);
    key_item_t it;
    it.key = key;
    it.drain = drain;
    it.paced = paced;
    pending_keys.push_back(it);
  endtask

  // driver: bursts with random gaps on paced items, optional drain pause
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        took = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (pending_keys.size() == 0) begin
        start <= 1'b0;
      end else if (pending_keys[0].drain && expected_tallies.size() != 0) begin
        start <= 1'b0;
      end else if (pending_keys[0].paced && gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else begin
        start <= 1'b1;
        in_key <= pending_keys[0].key;
      end
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    tally_t want;
    if (rst_n) begin
      if (out_valid) begin
        status_seen[out_status]++;
        if (int'(out_count) > top_count) top_count = int'(out_count);
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result slot %0d count %0d status %0d",
                   $time, out_slot, out_count, out_status);
          err_count++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot);
            err_count++;
          end
          if (out_count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, out_count);
            err_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %s actual %0d",
                     $time, want.status.name(), out_status);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_tallies.push_back(count_key(in_key));
        void'(pending_keys.pop_front());
        took = 1'b1;
      end
    end
  end

  initial begin
    int pick;
    logic [KEY_W-1:0] k;
    // zero key, extremes, collisions and wraparound past the last slot
    queue_key(16'h0000, 1'b0, 1'b0);
    queue_key(16'hFFFF, 1'b0, 1'b0);
    queue_key(16'h0007, 1'b0, 1'b0);
    queue_key(16'h000F, 1'b0, 1'b0);
    queue_key(16'hFFFF, 1'b0, 1'b0);
    queue_key(16'h000F, 1'b0, 1'b0);
    queue_key(16'h0008, 1'b0, 1'b0);
    queue_key(16'h0001, 1'b0, 1'b0);
    queue_key(16'h0000, 1'b0, 1'b0);
    queue_key(16'h8000, 1'b0, 1'b0);
    queue_key(16'h0001, 1'b0, 1'b0);
    queue_key(16'h0005, 1'b0, 1'b0);
    queue_key(16'hFFFE, 1'b0, 1'b0);
    queue_key(16'h1234, 1'b0, 1'b0);
    queue_key(16'h0006, 1'b0, 1'b0);
    queue_key(16'h0007, 1'b0, 1'b0);
    queue_key(16'h8000, 1'b0, 1'b0);
    stored_pool = '{16'hFFFF, 16'h0007, 16'h000F, 16'h0008,
                    16'h0001, 16'h8000, 16'h0005, 16'hFFFE};
    // random part on the full table: stored keys, absent keys, zero keys
    for (int i = 0; i < RANDOM_KEYS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) k = stored_pool[$urandom_range(0, stored_pool.size() - 1)];
      else if (pick < 90) k = KEY_W'($urandom_range(1, 65535));
      else k = '0;
      queue_key(k, (i == 0) || ($urandom_range(0, 99) == 0), 1'b1);
    end
    while (pending_keys.size() != 0 || expected_tallies.size() != 0) @(posedge clk);
    repeat (TABLE_SIZE + 16) @(posedge clk);
    $display("keys checked: %0d new, %0d present, %0d full, %0d zero",
             status_seen[ST_NEW], status_seen[ST_PRESENT],
             status_seen[ST_FULL], status_seen[ST_ZERO]);
    $display("highest count seen %0d, mismatches %0d", top_count, err_count);
    if (err_count == 0) begin
      $display("linear_probe_key_counter_core_test: clean");
    end else begin
      $display("linear_probe_key_counter_core_test: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d keys pending, %0d results outstanding",
             $time, pending_keys.size(), expected_tallies.size());
    $display("linear_probe_key_counter_core_test: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lpkc_pkg.sv
rtl/lpkc_front.sv
rtl/lpkc_queue.sv
rtl/lpkc_back.sv
rtl/linear_probe_key_counter_core.sv
tb/linear_probe_key_counter_core_test.sv
